/* src/sfd_pkg.sv */
// Shared types and constants of the serial frame deframer.
// Used by every module under src; depends on nothing.
package sfd_pkg;

    localparam logic [15:0] MIN_FRAME_LENGTH = 16'd6;
    localparam logic [15:0] PAYLOAD_START    = 16'd5;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd261;
    localparam logic [7:0]  HEADER_RESET     = 8'd0;
    localparam logic [7:0]  FOOTER_RESET     = 8'd0;

    localparam logic [1:0] CFG_HEADER_VALUE     = 2'd0;
    localparam logic [1:0] CFG_FOOTER_VALUE     = 2'd1;
    localparam logic [1:0] CFG_MAX_FRAME_LENGTH = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_ID      = 3'd3,
        PH_CMD     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_FOOTER  = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_PAYLOAD    = 3'd0,
        ST_RECEIVED   = 3'd1,
        ST_BAD_HEADER = 3'd2,
        ST_BAD_SIZE   = 3'd3,
        ST_BAD_FOOTER = 3'd4,
        ST_TIMEOUT    = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0]  header_value;
        logic [7:0]  footer_value;
        logic [15:0] max_frame_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       read_timeout;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  frame_id;
        logic [7:0]  frame_command;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        frame_end;
    } result_t;

endpackage

/* src/sfd_cfg_regs.sv */
// Configuration register file of the serial frame deframer.
// Depends on sfd_pkg for the register indexes and the cfg_t type.
module sfd_cfg_regs (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  logic [1:0]      wr_index,
    input  logic [15:0]     wr_data,
    output sfd_pkg::cfg_t   cfg
);
    import sfd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                CFG_HEADER_VALUE:     cfg_next.header_value = wr_data[7:0];
                CFG_FOOTER_VALUE:     cfg_next.footer_value = wr_data[7:0];
                CFG_MAX_FRAME_LENGTH: cfg_next.max_frame_length = wr_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_value     <= HEADER_RESET;
            cfg_reg.footer_value     <= FOOTER_RESET;
            cfg_reg.max_frame_length <= MAX_LENGTH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/sfd_in_stage.sv */
// Input register stage of the serial frame deframer.
// Holds one accepted item until the core takes it; depends on sfd_pkg.
module sfd_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  sfd_pkg::in_item_t in_item,
    output logic              out_valid,
    input  logic              out_take,
    output sfd_pkg::in_item_t out_item
);
    import sfd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready = !valid_reg || out_take;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* src/sfd_core.sv */
// Frame parser and result register of the serial frame deframer.
// Depends on sfd_pkg for the phase, status, item and result types.
module sfd_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  sfd_pkg::cfg_t     cfg,
    input  logic              item_valid,
    output logic              item_take,
    input  sfd_pkg::in_item_t item,
    output logic              res_valid,
    input  logic              res_ready,
    output sfd_pkg::result_t  res
);
    import sfd_pkg::*;

    phase_t      phase_reg,     phase_next;
    logic [15:0] pos_reg,       pos_next;
    logic [15:0] len_reg,       len_next;
    logic [7:0]  header_reg,    header_next;
    logic [7:0]  id_reg,        id_next;
    logic [7:0]  cmd_reg,       cmd_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;

    logic        consume;
    logic        emit;
    logic        finish;
    result_t     result;
    logic [15:0] full_len;
    logic [16:0] pos_plus_two;

    assign item_take    = !out_valid_reg || res_ready;
    assign consume      = item_valid && item_take;
    assign full_len     = {len_reg[15:8], item.rx_byte};
    assign pos_plus_two = {1'b0, pos_reg} + 17'd2;

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        header_next = header_reg;
        id_next     = id_reg;
        cmd_next    = cmd_reg;
        emit        = 1'b0;
        finish      = 1'b0;
        result.status        = ST_PAYLOAD;
        result.frame_id      = id_reg;
        result.frame_command = cmd_reg;
        result.payload_byte  = 8'd0;
        result.payload_index = 16'd0;
        result.frame_end     = 1'b0;

        if (item.read_timeout) begin
            finish        = 1'b1;
            result.status = ST_TIMEOUT;
        end else begin
            pos_next = pos_reg + 16'd1;
            case (phase_reg)
                PH_HEADER: begin
                    header_next = item.rx_byte;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    len_next   = {item.rx_byte, 8'd0};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_next = full_len;
                    if (header_reg != cfg.header_value) begin
                        finish        = 1'b1;
                        result.status = ST_BAD_HEADER;
                    end else if (full_len < MIN_FRAME_LENGTH
                                 || full_len > cfg.max_frame_length) begin
                        finish        = 1'b1;
                        result.status = ST_BAD_SIZE;
                    end else begin
                        phase_next = PH_ID;
                    end
                end
                PH_ID: begin
                    id_next    = item.rx_byte;
                    phase_next = PH_CMD;
                end
                PH_CMD: begin
                    cmd_next   = item.rx_byte;
                    phase_next = (len_reg == MIN_FRAME_LENGTH) ? PH_FOOTER : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    emit                 = 1'b1;
                    result.payload_byte  = item.rx_byte;
                    result.payload_index = pos_reg - PAYLOAD_START;
                    if (pos_plus_two >= {1'b0, len_reg}) begin
                        phase_next = PH_FOOTER;
                    end
                end
                PH_FOOTER: begin
                    finish        = 1'b1;
                    result.status = (item.rx_byte == cfg.footer_value) ?
                                    ST_RECEIVED : ST_BAD_FOOTER;
                end
                default: begin
                    phase_next  = PH_HEADER;
                    pos_next    = 16'd0;
                    len_next    = 16'd0;
                    header_next = 8'd0;
                    id_next     = 8'd0;
                    cmd_next    = 8'd0;
                end
            endcase
        end

        if (finish) begin
            emit             = 1'b1;
            result.frame_end = 1'b1;
            phase_next       = PH_HEADER;
            pos_next         = 16'd0;
            len_next         = 16'd0;
            header_next      = 8'd0;
            id_next          = 8'd0;
            cmd_next         = 8'd0;
        end

        out_valid_next = out_valid_reg;
        if (item_take) begin
            out_valid_next = item_valid && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= 16'd0;
            len_reg       <= 16'd0;
            header_reg    <= 8'd0;
            id_reg        <= 8'd0;
            cmd_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (consume) begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                len_reg    <= len_next;
                header_reg <= header_next;
                id_reg     <= id_next;
                cmd_reg    <= cmd_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && emit) begin
            out_reg <= result;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Only payload items leave a frame open; every other status closes it.
    a_payload_not_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((out_reg.status == ST_PAYLOAD) != out_reg.frame_end))
        else $error("frame_end does not match status");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && finish) |=> (phase_reg == PH_HEADER && pos_reg == 16'd0
                                 && id_reg == 8'd0 && cmd_reg == 8'd0))
        else $error("frame state not cleared after a final result");

    a_payload_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (len_reg > MIN_FRAME_LENGTH))
        else $error("payload phase entered with a frame that has no payload");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !res_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("result register changed while stalled");

    a_no_emit_without_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg && !item_valid) |=> !out_valid_reg)
        else $error("result appeared without an item");

endmodule

/* src/serial_frame_deframer.sv */
// Top level of the serial frame deframer: configuration registers, input
// register stage and frame parser. Depends on sfd_pkg and the sfd_ modules.
//
// Usage: received bytes enter on the s_ channel, one item per byte, with
// s_tuser high when the wait for a byte expired. Results leave on the m_
// channel: payload bytes as they arrive, tagged with the frame id and
// command, and one final status per frame (received, bad header, bad size,
// bad footer, timeout) marked by m_tlast. Header, length, id and command
// bytes give no result, save a bad header or bad size on the low length
// byte. A consumer drops the payload of a frame whose final status is bad
// footer. The cfg channel writes header_value (index 0), footer_value (index
// 1) and max_frame_length (index 2) and is always ready; other indexes are
// ignored. Write it only while no frame item is in flight. One item is
// accepted every cycle while the receiver does not stall; the rate is set by
// the single parser stage between the input register and the result
// register. When the receiver stalls, the result register holds and s_tready
// falls once the input register is full. Reset clears the frame state,
// empties both registers and loads the register defaults (max length 261).
module serial_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] read_timeout
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] frame_id, [15:8] frame_command,
                                   // [23:16] payload_byte, [39:24] payload_index
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast,   // frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sfd_pkg::*;

    cfg_t     cfg;
    in_item_t s_item;
    in_item_t core_item;
    logic     core_valid;
    logic     core_take;
    result_t  res;

    assign cfg_ready           = 1'b1;
    assign s_item.rx_byte      = s_tdata;
    assign s_item.read_timeout = s_tuser;

    sfd_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    sfd_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (core_valid),
        .out_take  (core_take),
        .out_item  (core_item)
    );

    sfd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (core_valid),
        .item_take  (core_take),
        .item       (core_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {res.payload_index, res.payload_byte, res.frame_command, res.frame_id};
    assign m_tuser = res.status;
    assign m_tlast = res.frame_end;

endmodule
